>>> rtl/ffra_pkg.sv
// Shared types and constants for the first-fit region allocator.
`default_nettype none

package ffra_pkg;

    // Field widths of the request and response items, and widths of the used total and sums.
    localparam int ADDR_BITS  = 32;
    localparam int OWNER_BITS = 16;
    localparam int USED_BITS  = ADDR_BITS + 1;
    localparam int SUM_BITS   = ADDR_BITS + 2;

    // Request type codes.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Response status codes.
    typedef enum logic [2:0] {
        ST_PLACED    = 3'd0,
        ST_NO_ROOM   = 3'd1,
        ST_FULL      = 3'd2,
        ST_FREED     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // One request item.
    typedef struct packed {
        logic                  req_type;
        logic [OWNER_BITS-1:0] owner_id;
        logic [ADDR_BITS-1:0]  region_size;
    } t_req;

    // One response item.
    typedef struct packed {
        logic [2:0]           status;
        logic [ADDR_BITS-1:0] start_addr;
        logic [ADDR_BITS-1:0] end_addr;
    } t_rsp;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_REPLY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    scan_clear;
        logic    scan_step;
        logic    do_insert;
        logic    do_remove;
        logic    set_status;
        t_status status;
        logic    write_rsp;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic cap_fail;
        logic table_full;
        logic scan_end;
        logic fit;
        logic owner_hit;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/ffra_datapath.sv
// Region table, scan registers, arithmetic and response register of the allocator.
`default_nettype none

module ffra_datapath
    import ffra_pkg::*;
#(
    parameter int MAX_REGIONS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [ADDR_BITS-1:0] i_cfg_wdata,
    input  wire t_req                 i_req,
    input  wire logic                 i_rsp_ready,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    output logic                      o_rsp_valid,
    output t_rsp                      o_rsp
);

    localparam int IDX_BITS = $clog2(MAX_REGIONS);
    localparam int CNT_BITS = $clog2(MAX_REGIONS + 1);

    // Region table: valid entries form a prefix of length r_count.
    logic [OWNER_BITS-1:0] r_owner [MAX_REGIONS];
    logic [ADDR_BITS-1:0]  r_start [MAX_REGIONS];
    logic [ADDR_BITS-1:0]  r_end   [MAX_REGIONS];
    logic [CNT_BITS-1:0]   r_count;
    logic [USED_BITS-1:0]  r_used;
    logic [ADDR_BITS-1:0]  r_total;

    // Scan position, base of the gap under test, the captured request and the pending response.
    logic [CNT_BITS-1:0]   r_idx;
    logic [USED_BITS-1:0]  r_base;
    t_req                  r_req;
    t_rsp                  r_pend;

    // Response register.
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic [IDX_BITS-1:0]   rd_idx;
    logic [OWNER_BITS-1:0] rd_owner;
    logic [ADDR_BITS-1:0]  rd_start;
    logic [ADDR_BITS-1:0]  rd_end;
    logic [SUM_BITS-1:0]   w_need;
    logic [SUM_BITS-1:0]   w_fit_sum;
    logic [SUM_BITS-1:0]   w_limit;
    logic [USED_BITS-1:0]  w_new_end;
    logic [USED_BITS-1:0]  w_words;
    logic                  w_scan_end;

    // Read the entry under the scan pointer.
    assign rd_idx   = r_idx[IDX_BITS-1:0];
    assign rd_owner = r_owner[rd_idx];
    assign rd_start = r_start[rd_idx];
    assign rd_end   = r_end[rd_idx];

    // Capacity check, gap fit check and derived values.
    assign w_scan_end = (r_idx == r_count);
    assign w_need     = {1'b0, r_used} + {2'b00, r_req.region_size};
    assign w_fit_sum  = {1'b0, r_base} + {2'b00, r_req.region_size};
    assign w_limit    = w_scan_end ? {2'b00, r_total} : {2'b00, rd_start};
    assign w_new_end  = r_base + {1'b0, r_req.region_size} - USED_BITS'(1);
    assign w_words    = {1'b0, rd_end} - {1'b0, rd_start} + USED_BITS'(1);

    always_comb begin
        o_stat.is_free    = (r_req.req_type == REQ_FREE);
        o_stat.cap_fail   = (r_req.region_size == '0) || (w_need > {2'b00, r_total});
        o_stat.table_full = (r_count == CNT_BITS'(MAX_REGIONS));
        o_stat.scan_end   = w_scan_end;
        o_stat.fit        = (w_fit_sum <= w_limit);
        o_stat.owner_hit  = (rd_owner == r_req.owner_id);
        o_stat.out_free   = !r_out_valid || i_rsp_ready;
    end

    // Per-entry update: shift up on insert, shift down on remove.
    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_entry
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == MAX_REGIONS - 1) ? g : g + 1;

        always_ff @(posedge i_clk) begin
            if (i_cmd.do_insert) begin
                if (CNT_BITS'(g) == r_idx) begin
                    r_owner[g] <= r_req.owner_id;
                    r_start[g] <= r_base[ADDR_BITS-1:0];
                    r_end[g]   <= w_new_end[ADDR_BITS-1:0];
                end else if (g > 0 && CNT_BITS'(g) > r_idx && CNT_BITS'(g) <= r_count) begin
                    r_owner[g] <= r_owner[PREV];
                    r_start[g] <= r_start[PREV];
                    r_end[g]   <= r_end[PREV];
                end
            end else if (i_cmd.do_remove) begin
                if (CNT_BITS'(g) >= r_idx && CNT_BITS'(g + 1) < r_count) begin
                    r_owner[g] <= r_owner[NEXT];
                    r_start[g] <= r_start[NEXT];
                    r_end[g]   <= r_end[NEXT];
                end
            end
        end
    end

    // Fill count, used total, capacity and response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_used      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            if (i_cmd.do_insert) begin
                r_count <= r_count + CNT_BITS'(1);
                r_used  <= w_need[USED_BITS-1:0];
            end else if (i_cmd.do_remove) begin
                r_count <= r_count - CNT_BITS'(1);
                r_used  <= (r_used >= w_words) ? r_used - w_words : '0;
            end
            if (i_cmd.write_rsp) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, scan registers and response payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.scan_clear) begin
            r_idx  <= '0;
            r_base <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx  <= r_idx + CNT_BITS'(1);
            r_base <= {1'b0, rd_end} + USED_BITS'(1);
        end
        if (i_cmd.set_status) begin
            r_pend.status <= i_cmd.status;
            if (i_cmd.status == ST_PLACED) begin
                r_pend.start_addr <= r_base[ADDR_BITS-1:0];
                r_pend.end_addr   <= w_new_end[ADDR_BITS-1:0];
            end else begin
                r_pend.start_addr <= '0;
                r_pend.end_addr   <= '0;
            end
        end
        if (i_cmd.write_rsp) begin
            r_out <= r_pend;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_REGIONS))
        else $error("region count exceeds table size");

    // An insert is only issued while the table has a free row.
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_insert |-> (r_count != CNT_BITS'(MAX_REGIONS)))
        else $error("insert into a full table");

    // A remove hits a valid entry and drops the count by one.
    a_remove_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_remove |-> (r_idx < r_count) ##1 (r_count == $past(r_count) - CNT_BITS'(1)))
        else $error("remove outside the valid entries");

endmodule

`default_nettype wire

>>> rtl/ffra_ctrl.sv
// Controller state machine of the first-fit region allocator.
`default_nettype none

module ffra_ctrl
    import ffra_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_req_valid,
    input  wire t_stat i_stat,
    output logic       o_req_ready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        o_cmd.status = ST_PLACED;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.is_free) begin
                    o_cmd.scan_clear = 1'b1;
                    n_state          = S_SCAN;
                end else if (i_stat.cap_fail) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NO_ROOM;
                    n_state          = S_REPLY;
                end else if (i_stat.table_full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                    n_state          = S_REPLY;
                end else begin
                    o_cmd.scan_clear = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.is_free) begin
                    // Look for the lowest-addressed region of the owner.
                    if (i_stat.scan_end) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOT_FOUND;
                        n_state          = S_REPLY;
                    end else if (i_stat.owner_hit) begin
                        o_cmd.do_remove  = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_FREED;
                        n_state          = S_REPLY;
                    end else begin
                        o_cmd.scan_step = 1'b1;
                    end
                end else begin
                    // Walk the gaps from the lowest address upward.
                    if (i_stat.fit) begin
                        o_cmd.do_insert  = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_PLACED;
                        n_state          = S_REPLY;
                    end else if (i_stat.scan_end) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NO_ROOM;
                        n_state          = S_REPLY;
                    end else begin
                        o_cmd.scan_step = 1'b1;
                    end
                end
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.write_rsp = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A response is only loaded when the output register can take it.
    a_rsp_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write_rsp |-> i_stat.out_free)
        else $error("response loaded over an unread response");

    // The table is never changed outside a scan.
    a_update_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.do_insert || o_cmd.do_remove) |-> (r_state == S_SCAN) ##1 (r_state == S_REPLY))
        else $error("table update outside a scan");

    // A request is captured only on an accepting handshake.
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_req |-> (i_req_valid && o_req_ready))
        else $error("request captured without a handshake");

endmodule

`default_nettype wire

>>> rtl/first_fit_region_allocator.sv
// Top level of the first-fit region allocator: controller plus datapath.
//
// Usage: requests arrive on i_req (valid/ready); each one gives exactly one
// response on o_rsp (valid/ready). An allocate places region_size words in the
// lowest gap that fits in the space 0 .. total_mem-1 and returns its first and last
// address; a free removes the owner's lowest-addressed region. The capacity is
// written through i_cfg_we/i_cfg_wdata while no request is in flight.
// Timing: one request is handled at a time. The table is walked one entry per
// cycle through a single read port, between the check and the reply states;
// capacity and table-full failures skip the walk and go from the check straight
// to the reply. The default table has sixteen entries. A response appears in the
// same cycle in which the controller is idle again and can accept the next request.
// Reset (synchronous, active low) empties the table, clears the used total and
// sets the capacity to zero, so allocations fail until it is written.
// Stall: the response sits in an output register; the next request is taken
// while it waits, and that request's response waits for the register to drain.
`default_nettype none

module first_fit_region_allocator
    import ffra_pkg::*;
#(
    parameter int MAX_REGIONS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [ADDR_BITS-1:0] i_cfg_wdata,
    input  wire logic                 i_req_valid,
    output logic                      o_req_ready,
    input  wire t_req                 i_req,
    output logic                      o_rsp_valid,
    input  wire logic                 i_rsp_ready,
    output t_rsp                      o_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencing of check, scan, table update and response.
    ffra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_stat      (w_stat),
        .o_req_ready (o_req_ready),
        .o_cmd       (w_cmd)
    );

    // Region table and arithmetic.
    ffra_datapath #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_rsp_ready (i_rsp_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire
